/* src/qau_pkg.sv */
// Shared types, constants and operand tables for the quaternion arithmetic unit.
package qau_pkg;

  localparam int W        = 24;
  localparam int PROD_W   = 2 * W;
  localparam int ACC_W    = 52;
  localparam int SQ_W     = 50;
  localparam int LEN_W    = 26;
  localparam int NUM_W    = 44;
  localparam int SQ_STEPS = 25;
  localparam int DV_STEPS = 44;
  localparam int CNT_W    = 6;

  typedef logic signed [W-1:0] q_t;

  localparam q_t Q_ONE = 24'sh100000;
  localparam q_t Q_MAX = 24'sh7fffff;
  localparam q_t Q_MIN = 24'sh800000;

  localparam logic signed [ACC_W-1:0] ACC_ONE  = 52'sh100_0000_0000;
  localparam logic signed [ACC_W-1:0] ACC_HALF = 52'sh8_0000;
  localparam logic [LEN_W-1:0]        LEN_MAX  = 26'h7fffff;
  localparam logic [NUM_W-1:0]        Q_POS_LIM = 44'h7fffff;
  localparam logic [NUM_W-1:0]        Q_NEG_LIM = 44'h800000;

  // operation codes
  localparam logic [2:0] F_LOAD  = 3'd0;
  localparam logic [2:0] F_QMUL  = 3'd1;
  localparam logic [2:0] F_VMUL  = 3'd2;
  localparam logic [2:0] F_CONJ  = 3'd3;
  localparam logic [2:0] F_NORM  = 3'd4;
  localparam logic [2:0] F_SCALE = 3'd5;
  localparam logic [2:0] F_ROT   = 3'd6;
  localparam logic [2:0] F_LEN   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // component indexes
  localparam logic [1:0] IX_X = 2'd0;
  localparam logic [1:0] IX_Y = 2'd1;
  localparam logic [1:0] IX_Z = 2'd2;
  localparam logic [1:0] IX_W = 2'd3;

  typedef struct packed {
    logic [1:0] a;
    logic       b_rhs;
    logic [1:0] b;
    logic       neg;
  } term_t;

  typedef struct packed {
    logic       latch;
    logic       mul;
    logic       preset;
    logic       acc;
    logic       rnd;
    logic       sq_init;
    logic       sq_step;
    logic       sq_fin;
    logic       len_out;
    logic       set_zero;
    logic       dv_init;
    logic       dv_step;
    logic       dv_fin;
    logic       emit;
    logic       last;
    logic       commit;
    logic       clr_sat;
    logic [2:0] func;
    logic [1:0] row;
    logic [1:0] elem;
    logic [1:0] term;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic len_zero;
  } stat_t;

  typedef struct packed {
    q_t   v;
    logic s;
  } sat_t;

  function automatic term_t mk(logic [1:0] a, logic b_rhs, logic [1:0] b, logic neg);
    term_t t;
    t.a     = a;
    t.b_rhs = b_rhs;
    t.b     = b;
    t.neg   = neg;
    return t;
  endfunction

  function automatic term_t hamilton_term(logic [1:0] elem, logic [1:0] term);
    term_t t;
    unique case ({elem, term})
      4'h0: t = mk(IX_X, 1'b1, IX_W, 1'b0);
      4'h1: t = mk(IX_W, 1'b1, IX_X, 1'b0);
      4'h2: t = mk(IX_Y, 1'b1, IX_Z, 1'b0);
      4'h3: t = mk(IX_Z, 1'b1, IX_Y, 1'b1);
      4'h4: t = mk(IX_Y, 1'b1, IX_W, 1'b0);
      4'h5: t = mk(IX_W, 1'b1, IX_Y, 1'b0);
      4'h6: t = mk(IX_Z, 1'b1, IX_X, 1'b0);
      4'h7: t = mk(IX_X, 1'b1, IX_Z, 1'b1);
      4'h8: t = mk(IX_Z, 1'b1, IX_W, 1'b0);
      4'h9: t = mk(IX_W, 1'b1, IX_Z, 1'b0);
      4'ha: t = mk(IX_X, 1'b1, IX_Y, 1'b0);
      4'hb: t = mk(IX_Y, 1'b1, IX_X, 1'b1);
      4'hc: t = mk(IX_W, 1'b1, IX_W, 1'b0);
      4'hd: t = mk(IX_X, 1'b1, IX_X, 1'b1);
      4'he: t = mk(IX_Y, 1'b1, IX_Y, 1'b1);
      default: t = mk(IX_Z, 1'b1, IX_Z, 1'b1);
    endcase
    return t;
  endfunction

  function automatic term_t rot_term(logic [1:0] row, logic [1:0] elem, logic term);
    term_t t;
    case ({row, elem, term})
      5'b00_00_0: t = mk(IX_X, 1'b0, IX_Z, 1'b0);
      5'b00_00_1: t = mk(IX_W, 1'b0, IX_Y, 1'b1);
      5'b00_01_0: t = mk(IX_Y, 1'b0, IX_Z, 1'b0);
      5'b00_01_1: t = mk(IX_W, 1'b0, IX_X, 1'b0);
      5'b00_10_0: t = mk(IX_X, 1'b0, IX_X, 1'b1);
      5'b00_10_1: t = mk(IX_Y, 1'b0, IX_Y, 1'b1);
      5'b01_00_0: t = mk(IX_X, 1'b0, IX_Y, 1'b0);
      5'b01_00_1: t = mk(IX_W, 1'b0, IX_Z, 1'b0);
      5'b01_01_0: t = mk(IX_X, 1'b0, IX_X, 1'b1);
      5'b01_01_1: t = mk(IX_Z, 1'b0, IX_Z, 1'b1);
      5'b01_10_0: t = mk(IX_Y, 1'b0, IX_Z, 1'b0);
      5'b01_10_1: t = mk(IX_W, 1'b0, IX_X, 1'b1);
      5'b10_00_0: t = mk(IX_Y, 1'b0, IX_Y, 1'b1);
      5'b10_00_1: t = mk(IX_Z, 1'b0, IX_Z, 1'b1);
      5'b10_01_0: t = mk(IX_X, 1'b0, IX_Y, 1'b0);
      5'b10_01_1: t = mk(IX_W, 1'b0, IX_Z, 1'b1);
      5'b10_10_0: t = mk(IX_X, 1'b0, IX_Z, 1'b0);
      5'b10_10_1: t = mk(IX_W, 1'b0, IX_Y, 1'b0);
      default:    t = mk(IX_X, 1'b0, IX_X, 1'b0);
    endcase
    return t;
  endfunction

  function automatic term_t term_sel(logic [2:0] func, logic [1:0] row, logic [1:0] elem,
                                     logic [1:0] term);
    term_t t;
    case (func)
      F_QMUL, F_VMUL: t = hamilton_term(elem, term);
      F_SCALE:        t = mk(elem, 1'b1, IX_W, 1'b0);
      F_ROT:          t = rot_term(row, elem, term[0]);
      default:        t = mk(term, 1'b0, term, 1'b0);
    endcase
    return t;
  endfunction

  function automatic logic is_diag(logic [1:0] row, logic [1:0] elem);
    return (row == 2'd0 && elem == 2'd2) || (row == 2'd1 && elem == 2'd1) ||
           (row == 2'd2 && elem == 2'd0);
  endfunction

  function automatic logic [1:0] last_term(logic [2:0] func);
    logic [1:0] n;
    case (func)
      F_SCALE: n = 2'd0;
      F_ROT:   n = 2'd1;
      default: n = 2'd3;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] last_elem(logic [2:0] func);
    return (func == F_ROT) ? 2'd2 : 2'd3;
  endfunction

  // Q11.40 to Q3.20, round half up, saturate
  function automatic sat_t rnd_sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic [ACC_W-21:0]       r;
    sat_t                    o;
    t = v + ACC_HALF;
    r = t[ACC_W-1:20];
    if (r[ACC_W-21:W-1] != {(ACC_W-20-W+1){r[ACC_W-21]}}) begin
      o.v = r[ACC_W-21] ? Q_MIN : Q_MAX;
      o.s = 1'b1;
    end else begin
      o.v = r[W-1:0];
      o.s = 1'b0;
    end
    return o;
  endfunction

  function automatic sat_t neg_sat(q_t v);
    sat_t o;
    if (v == Q_MIN) begin
      o.v = Q_MAX;
      o.s = 1'b1;
    end else begin
      o.v = -v;
      o.s = 1'b0;
    end
    return o;
  endfunction

endpackage

/* src/qau_ctrl.sv */
// Sequencer for the quaternion unit: steps terms, elements, rows and iterations.
module qau_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     func,
  input  qau_pkg::stat_t stat,
  output qau_pkg::cmd_t  cmd
);
  import qau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_RND  = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQF  = 4'd5;
  localparam logic [3:0] S_LCHK = 4'd6;
  localparam logic [3:0] S_DVI  = 4'd7;
  localparam logic [3:0] S_DV   = 4'd8;
  localparam logic [3:0] S_DVF  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  logic [3:0]       state, state_next;
  logic [2:0]       func_q, func_next;
  logic [1:0]       elem, elem_next;
  logic [1:0]       term, term_next;
  logic [1:0]       row, row_next;
  logic [CNT_W-1:0] iter, iter_next;
  logic             more_rows;

  assign in_stall  = (state != S_IDLE);
  assign more_rows = (func_q == F_ROT) && (row != 2'd2);

  always_comb begin
    state_next = state;
    func_next  = func_q;
    elem_next  = elem;
    term_next  = term;
    row_next   = row;
    iter_next  = iter;
    cmd        = '0;
    cmd.func   = func_q;
    cmd.row    = row;
    cmd.elem   = elem;
    cmd.term   = term;
    unique case (state)
      S_IDLE: begin
        cmd.func = func;
        if (in_valid) begin
          cmd.latch = 1'b1;
          func_next = func;
          elem_next = 2'd0;
          term_next = 2'd0;
          row_next  = 2'd0;
          state_next = (func == F_LOAD || func == F_CONJ) ? S_EMIT : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cmd.preset = (term == 2'd0);
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (term == last_term(func_q)) begin
          state_next = S_RND;
        end else begin
          term_next  = term + 2'd1;
          state_next = S_MUL;
        end
      end
      S_RND: begin
        if (func_q == F_NORM || func_q == F_LEN) begin
          cmd.sq_init = 1'b1;
          iter_next   = '0;
          state_next  = S_SQ;
        end else begin
          cmd.rnd = 1'b1;
          if (elem == last_elem(func_q)) begin
            state_next = S_EMIT;
          end else begin
            elem_next  = elem + 2'd1;
            term_next  = 2'd0;
            state_next = S_MUL;
          end
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        iter_next   = iter + 1'b1;
        if (iter == CNT_W'(SQ_STEPS - 1)) state_next = S_SQF;
      end
      S_SQF: begin
        cmd.sq_fin = 1'b1;
        state_next = S_LCHK;
      end
      S_LCHK: begin
        if (func_q == F_LEN) begin
          cmd.len_out = 1'b1;
          state_next  = S_EMIT;
        end else if (stat.len_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_EMIT;
        end else begin
          elem_next  = 2'd0;
          state_next = S_DVI;
        end
      end
      S_DVI: begin
        cmd.dv_init = 1'b1;
        iter_next   = '0;
        state_next  = S_DV;
      end
      S_DV: begin
        cmd.dv_step = 1'b1;
        iter_next   = iter + 1'b1;
        if (iter == CNT_W'(DV_STEPS - 1)) state_next = S_DVF;
      end
      S_DVF: begin
        cmd.dv_fin = 1'b1;
        if (elem == 2'd3) begin
          state_next = S_EMIT;
        end else begin
          elem_next  = elem + 2'd1;
          state_next = S_DVI;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = !more_rows;
          cmd.commit = (func_q != F_SCALE) && (func_q != F_ROT) && (func_q != F_LEN);
          if (more_rows) begin
            cmd.clr_sat = 1'b1;
            row_next    = row + 2'd1;
            elem_next   = 2'd0;
            term_next   = 2'd0;
            state_next  = S_MUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      func_q <= F_LOAD;
      elem  <= 2'd0;
      term  <= 2'd0;
      row   <= 2'd0;
      iter  <= '0;
    end else begin
      state <= state_next;
      func_q <= func_next;
      elem  <= elem_next;
      term  <= term_next;
      row   <= row_next;
      iter  <= iter_next;
    end
  end

endmodule

/* src/qau_dp.sv */
// Datapath: held quaternion, shared multiplier and accumulator, root and divide units.
module qau_dp (
  input  logic           clk,
  input  logic           rst,
  input  qau_pkg::cmd_t  cmd,
  output qau_pkg::stat_t stat,
  input  logic signed [23:0] rhs_x,
  input  logic signed [23:0] rhs_y,
  input  logic signed [23:0] rhs_z,
  input  logic signed [23:0] rhs_w,
  output logic           out_valid,
  input  logic           out_stall,
  output logic signed [23:0] out_a,
  output logic signed [23:0] out_b,
  output logic signed [23:0] out_c,
  output logic signed [23:0] out_d,
  output logic           last,
  output logic [1:0]     status
);
  import qau_pkg::*;

  q_t held [4];
  q_t rhs  [4];
  q_t res  [4];

  logic signed [PROD_W-1:0] prod;
  logic                     prod_neg;
  logic                     prod_shl;
  logic signed [ACC_W-1:0]  acc;
  logic                     sat;
  logic                     zst;

  logic [SQ_W-1:0]  sq_n, sq_r, sq_bit;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] dv_rem;
  logic [NUM_W-1:0] dv_q;
  logic             dv_neg;

  term_t                    ts;
  q_t                       a_val, b_val;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  term_ext, term_val;
  sat_t                     rs;
  sat_t                     cj [3];
  logic [SQ_W:0]            sq_trial;
  q_t                       dc;
  logic [W-1:0]             dm;
  logic [NUM_W-1:0]         dnum;
  logic [LEN_W:0]           dv_sh, dv_trial;

  assign ts        = term_sel(cmd.func, cmd.row, cmd.elem, cmd.term);
  assign a_val     = held[ts.a];
  assign b_val     = ts.b_rhs ? rhs[ts.b] : held[ts.b];
  assign prod_next = a_val * b_val;

  always_comb begin
    term_ext = ACC_W'(prod);
    if (prod_shl) term_ext = term_ext <<< 1;
    term_val = prod_neg ? -term_ext : term_ext;
  end

  assign rs       = rnd_sat(acc);
  assign cj[0]    = neg_sat(held[0]);
  assign cj[1]    = neg_sat(held[1]);
  assign cj[2]    = neg_sat(held[2]);
  assign sq_trial = {1'b0, sq_r} + {1'b0, sq_bit};
  assign dc       = held[cmd.elem];
  assign dm       = dc[W-1] ? W'(-dc) : W'(dc);
  assign dnum     = {dm, 20'b0} + NUM_W'(len_q >> 1);
  assign dv_sh    = {dv_rem, dv_q[NUM_W-1]};
  assign dv_trial = dv_sh - {1'b0, len_q};

  assign stat.out_free = !out_valid || !out_stall;
  assign stat.len_zero = (len_q == '0);

  // held quaternion and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      held[0]   <= '0;
      held[1]   <= '0;
      held[2]   <= '0;
      held[3]   <= Q_ONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (cmd.commit && !zst) begin
          held <= res;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_a  <= res[0];
      out_b  <= res[1];
      out_c  <= res[2];
      out_d  <= (cmd.func == F_ROT) ? '0 : res[3];
      last   <= cmd.last;
      status <= zst ? ST_ZERO : (sat ? ST_SAT : ST_OK);
    end
  end

  // operand capture, load and conjugate, multiply-accumulate, rounding, length and quotient results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rhs[0] <= rhs_x;
      rhs[1] <= rhs_y;
      rhs[2] <= rhs_z;
      rhs[3] <= (cmd.func == F_VMUL) ? '0 : rhs_w;
      sat    <= 1'b0;
      zst    <= 1'b0;
      if (cmd.func == F_LOAD) begin
        res[0] <= rhs_x;
        res[1] <= rhs_y;
        res[2] <= rhs_z;
        res[3] <= rhs_w;
      end else if (cmd.func == F_CONJ) begin
        res[0] <= cj[0].v;
        res[1] <= cj[1].v;
        res[2] <= cj[2].v;
        res[3] <= held[3];
        sat    <= cj[0].s | cj[1].s | cj[2].s;
      end
    end
    if (cmd.clr_sat) sat <= 1'b0;
    if (cmd.mul) begin
      prod     <= prod_next;
      prod_neg <= ts.neg;
      prod_shl <= (cmd.func == F_ROT);
      if (cmd.preset) begin
        acc <= ((cmd.func == F_ROT) && is_diag(cmd.row, cmd.elem)) ? ACC_ONE : '0;
      end
    end
    if (cmd.acc) acc <= acc + term_val;
    if (cmd.rnd) begin
      res[cmd.elem] <= rs.v;
      if (rs.s) sat <= 1'b1;
    end
    if (cmd.len_out) begin
      if (len_q > LEN_MAX) begin
        res[0] <= Q_MAX;
        sat    <= 1'b1;
      end else begin
        res[0] <= W'(len_q);
      end
      res[1] <= '0;
      res[2] <= '0;
      res[3] <= '0;
    end
    if (cmd.set_zero) begin
      res <= held;
      zst <= 1'b1;
    end
    if (cmd.dv_fin) begin
      if (dv_neg) begin
        if (dv_q > Q_NEG_LIM) begin
          res[cmd.elem] <= Q_MIN;
          sat           <= 1'b1;
        end else begin
          res[cmd.elem] <= W'(~dv_q[W-1:0] + 1'b1);
        end
      end else begin
        if (dv_q > Q_POS_LIM) begin
          res[cmd.elem] <= Q_MAX;
          sat           <= 1'b1;
        end else begin
          res[cmd.elem] <= dv_q[W-1:0];
        end
      end
    end
  end

  // square root, one result bit per cycle, rounded to nearest
  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_n   <= SQ_W'(acc[48:0]);
      sq_r   <= '0;
      sq_bit <= SQ_W'(1) << 48;
    end else if (cmd.sq_step) begin
      if ({1'b0, sq_n} >= sq_trial) begin
        sq_n <= sq_n - sq_trial[SQ_W-1:0];
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.sq_fin) begin
      len_q <= LEN_W'(sq_r) + ((sq_n > sq_r) ? LEN_W'(1) : LEN_W'(0));
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.dv_init) begin
      dv_q   <= dnum;
      dv_rem <= '0;
      dv_neg <= dc[W-1];
    end else if (cmd.dv_step) begin
      if (!dv_trial[LEN_W]) begin
        dv_rem <= dv_trial[LEN_W-1:0];
        dv_q   <= {dv_q[NUM_W-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh[LEN_W-1:0];
        dv_q   <= {dv_q[NUM_W-2:0], 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("undefined status code");
  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ZERO) |-> last)
    else $error("zero-length status on a non-final result");
`endif

endmodule

/* src/quaternion_arithmetic_unit.sv */
// Top level of the quaternion arithmetic unit: sequencer plus datapath.
// Operations run on the shared multiplier, which takes each term through a multiply
// and an accumulate state, the 25-step root and the 44-step divider.
// One operation at a time; the next transaction is taken once the last result
// sits in the output register. Synchronous reset: idle, held = (0, 0, 0, 1.0).
module quaternion_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        func,
  input  logic signed [23:0] rhs_x,
  input  logic signed [23:0] rhs_y,
  input  logic signed [23:0] rhs_z,
  input  logic signed [23:0] rhs_w,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [23:0] out_a,
  output logic signed [23:0] out_b,
  output logic signed [23:0] out_c,
  output logic signed [23:0] out_d,
  output logic              last,
  output logic [1:0]        status
);
  import qau_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: owns the input handshake, walks terms, elements, rows and
  // iteration counts for the selected operation
  qau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: holds the accumulator quaternion and drives the output
  // register, which frees the input side while a result waits
  qau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .rhs_x     (rhs_x),
    .rhs_y     (rhs_y),
    .rhs_z     (rhs_z),
    .rhs_w     (rhs_w),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .out_d     (out_d),
    .last      (last),
    .status    (status)
  );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the quaternion arithmetic unit.
`timescale 1ns / 1ps

module tb;
  import qau_pkg::*;

  typedef struct packed {
    logic [2:0] func;
    q_t         x;
    q_t         y;
    q_t         z;
    q_t         w;
  } op_t;

  typedef struct packed {
    q_t         a;
    q_t         b;
    q_t         c;
    q_t         d;
    logic       last;
    logic [1:0] status;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = F_LOAD;
  logic signed [23:0] rhs_x = '0, rhs_y = '0, rhs_z = '0, rhs_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_a, out_b, out_c, out_d;
  logic last;
  logic [1:0] status;

  quaternion_arithmetic_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .rhs_x(rhs_x), .rhs_y(rhs_y), .rhs_z(rhs_z), .rhs_w(rhs_w),
    .out_valid(out_valid), .out_stall(out_stall), .out_a(out_a), .out_b(out_b),
    .out_c(out_c), .out_d(out_d), .last(last), .status(status)
  );

  // Pending operations, results still owed by the block, error count.
  op_t  pending_ops[$];
  res_t owed_results[$];
  int   mismatches = 0;
  int   send_idle_pct = 16;
  int   recv_idle_pct = 63;
  bit   stim_done = 1'b0;
  longint cycles = 0;

  // Predicted accumulator, rounded to Q3.20 as the block holds it.
  longint acc_x, acc_y, acc_z, acc_w;
  bit     sat_seen;

  initial begin
    forever #4 clk = ~clk;
  end

  // Saturate to 24 bits and note it.
  function automatic longint clamp(longint v);
    if (v > 64'sd8388607) begin
      sat_seen = 1'b1;
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      sat_seen = 1'b1;
      return -64'sd8388608;
    end
    return v;
  endfunction

  // Q23.40 to Q3.20, ties toward +infinity, then saturate.
  function automatic longint round40(longint v);
    return clamp((v + 64'sd524288) >>> 20);
  endfunction

  // Square root rounded to nearest.
  function automatic longint root_near(longint s);
    longint r, lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint unit_div(longint c, longint len);
    longint m, q;
    m = (c < 0) ? -c : c;
    q = ((m <<< 20) + len / 2) / len;
    return clamp(c < 0 ? -q : q);
  endfunction

  function automatic longint energy();
    return acc_x * acc_x + acc_y * acc_y + acc_z * acc_z + acc_w * acc_w;
  endfunction

  task automatic owe(longint a, longint b, longint c, longint d, bit lst, logic [1:0] st);
    res_t r;
    r.a = q_t'(a);
    r.b = q_t'(b);
    r.c = q_t'(c);
    r.d = q_t'(d);
    r.last = lst;
    r.status = st;
    owed_results.push_back(r);
  endtask

  // Advance the predicted accumulator and queue what the block must return.
  task automatic predict_op(op_t op);
    longint x, y, z, w, rx, ry, rz, rw, len, e0, e1, e2;
    longint one;
    x = acc_x; y = acc_y; z = acc_z; w = acc_w;
    rx = op.x; ry = op.y; rz = op.z; rw = op.w;
    one = 64'sd1 <<< 40;
    sat_seen = 1'b0;
    case (op.func)
      F_LOAD: begin
        acc_x = rx; acc_y = ry; acc_z = rz; acc_w = rw;
      end
      F_QMUL: begin
        acc_w = round40(w * rw - x * rx - y * ry - z * rz);
        acc_x = round40(x * rw + w * rx + y * rz - z * ry);
        acc_y = round40(y * rw + w * ry + z * rx - x * rz);
        acc_z = round40(z * rw + w * rz + x * ry - y * rx);
      end
      F_VMUL: begin
        acc_w = round40(-x * rx - y * ry - z * rz);
        acc_x = round40(w * rx + y * rz - z * ry);
        acc_y = round40(w * ry + z * rx - x * rz);
        acc_z = round40(w * rz + x * ry - y * rx);
      end
      F_CONJ: begin
        acc_x = clamp(-x); acc_y = clamp(-y); acc_z = clamp(-z);
      end
      F_NORM: begin
        len = root_near(energy());
        if (len == 0) begin
          owe(x, y, z, w, 1'b1, ST_ZERO);
          return;
        end
        acc_x = unit_div(x, len);
        acc_y = unit_div(y, len);
        acc_z = unit_div(z, len);
        acc_w = unit_div(w, len);
      end
      F_SCALE: begin
        e0 = round40(x * rw); e1 = round40(y * rw);
        e2 = round40(z * rw); len = round40(w * rw);
        owe(e0, e1, e2, len, 1'b1, sat_seen ? ST_SAT : ST_OK);
        return;
      end
      F_ROT: begin
        e0 = round40(2 * (x * z - w * y));
        e1 = round40(2 * (y * z + w * x));
        e2 = round40(one - 2 * (x * x + y * y));
        owe(e0, e1, e2, 0, 1'b0, sat_seen ? ST_SAT : ST_OK);
        sat_seen = 1'b0;
        e0 = round40(2 * (x * y + w * z));
        e1 = round40(one - 2 * (x * x + z * z));
        e2 = round40(2 * (y * z - w * x));
        owe(e0, e1, e2, 0, 1'b0, sat_seen ? ST_SAT : ST_OK);
        sat_seen = 1'b0;
        e0 = round40(one - 2 * (y * y + z * z));
        e1 = round40(2 * (x * y - w * z));
        e2 = round40(2 * (x * z + w * y));
        owe(e0, e1, e2, 0, 1'b1, sat_seen ? ST_SAT : ST_OK);
        return;
      end
      default: begin
        len = clamp(root_near(energy()));
        owe(len, 0, 0, 0, 1'b1, sat_seen ? ST_SAT : ST_OK);
        return;
      end
    endcase
    owe(acc_x, acc_y, acc_z, acc_w, 1'b1, sat_seen ? ST_SAT : ST_OK);
  endtask

  task automatic report_mismatch(string what, res_t got, res_t want);
    mismatches++;
    $display("ERROR %0t: %s got a=%h b=%h c=%h d=%h last=%b st=%0d want a=%h b=%h c=%h d=%h last=%b st=%0d",
             $time, what, got.a, got.b, got.c, got.d, got.last, got.status,
             want.a, want.b, want.c, want.d, want.last, want.status);
  endtask

  task automatic queue_op(logic [2:0] f, q_t x, q_t y, q_t z, q_t w);
    op_t op;
    op.func = f; op.x = x; op.y = y; op.z = z; op.w = w;
    pending_ops.push_back(op);
  endtask

  // Operand near unit size most of the time, else any bit pattern, an extreme or zero.
  function automatic q_t rand_comp();
    case ($urandom_range(0, 9))
      0: return q_t'($urandom);
      1: return Q_MAX;
      2: return Q_MIN;
      3: return '0;
      default: return q_t'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
    endcase
  endfunction

  // Driver: present the head of the queue at the falling edge; hold while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        func  <= pending_ops[0].func;
        rhs_x <= pending_ops[0].x;
        rhs_y <= pending_ops[0].y;
        rhs_z <= pending_ops[0].z;
        rhs_w <= pending_ops[0].w;
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: predict on accepted inputs, check accepted results.
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      cycles <= cycles + 1;
      if (in_valid && !in_stall) predict_op(pending_ops.pop_front());
      if (out_valid && !out_stall) begin
        got.a = out_a; got.b = out_b; got.c = out_c; got.d = out_d;
        got.last = last; got.status = status;
        if (owed_results.size() == 0) report_mismatch("unexpected result", got, got);
        else if (got !== owed_results[0]) report_mismatch("result", got, owed_results.pop_front());
        else void'(owed_results.pop_front());
      end
    end
  end

  // Watchdog: ~430 items, worst 3 results each, slow stalls, normalize the slowest op.
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n;
    acc_x = 0; acc_y = 0; acc_z = 0; acc_w = 64'sd1048576;
    repeat (10) @(posedge clk);
    rst <= 1'b1;
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset state through every op, extremes, zero-length normalize.
    queue_op(F_ROT, '0, '0, '0, '0);
    queue_op(F_LEN, '0, '0, '0, '0);
    queue_op(F_LOAD, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    queue_op(F_LEN, '0, '0, '0, '0);
    queue_op(F_CONJ, '0, '0, '0, '0);
    queue_op(F_SCALE, '0, '0, '0, Q_MAX);
    queue_op(F_ROT, '0, '0, '0, '0);
    queue_op(F_QMUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_op(F_NORM, '0, '0, '0, '0);
    queue_op(F_VMUL, Q_MAX, Q_MIN, 24'sh0fffff, '0);
    queue_op(F_LOAD, '0, '0, '0, '0);
    queue_op(F_NORM, '0, '0, '0, '0);
    queue_op(F_SCALE, '0, '0, '0, Q_MIN);
    queue_op(F_LOAD, 24'sh080000, 24'sh080000, 24'sh080000, 24'sh080000);
    queue_op(F_NORM, '0, '0, '0, '0);
    queue_op(F_QMUL, 24'sh000001, 24'shffffff, 24'sh000001, Q_ONE);
    queue_op(F_ROT, '0, '0, '0, '0);
    queue_op(F_LOAD, 24'sh000001, '0, '0, '0);
    queue_op(F_NORM, '0, '0, '0, '0);
    queue_op(F_LOAD, 24'shffffff, 24'sh000003, '0, '0);
    queue_op(F_SCALE, '0, '0, '0, 24'sh080000);

    // Random: occasional load amid a chain of random ops on mostly near-unit values.
    for (n = 0; n < 410; n++) begin
      if ($urandom_range(0, 5) == 0)
        queue_op(F_LOAD, rand_comp(), rand_comp(), rand_comp(), rand_comp());
      else
        queue_op(3'($urandom_range(0, 7)), rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if (n == 140) wait (pending_ops.size() == 0);
      if (n == 140) begin
        send_idle_pct = 63;
        recv_idle_pct = 16;
      end
      if (n == 280) wait (pending_ops.size() == 0);
      if (n == 280) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    wait (pending_ops.size() == 0 && !in_valid);
    wait (owed_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
